>>> design/fbm_pkg.sv
// fbm_pkg: shared types and constants for the fbm value noise density block
// used by every module under design/
// no dependencies

package fbm_pkg;

   // width of one noise sample and of the quotient, Q0.24
   localparam int NOISE_W = 24;

   // lattice coordinate width, Q32.16
   localparam int COORD_W = 48;

   // pipeline depth of one octave cell
   localparam int CELL_STAGES = 8;

   // width of the effective octave count
   localparam int OCT_W = 5;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OFFSET_X     = 3'd0,
      REG_OFFSET_Y     = 3'd1,
      REG_OFFSET_Z     = 3'd2,
      REG_FREQUENCY    = 3'd3,
      REG_OCTAVE_COUNT = 3'd4,
      REG_OCTAVE_GAIN  = 3'd5,
      REG_AMPLITUDE    = 3'd6,
      REG_BIAS         = 3'd7
   } csr_reg_type;

   // register reset values
   localparam logic [23:0] FREQUENCY_RST    = 24'd65536;
   localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd4;
   localparam logic [15:0] OCTAVE_GAIN_RST  = 16'd16384;
   localparam logic [23:0] AMPLITUDE_RST    = 24'd65536;

   // first octave weight, 1.0 in Q1.15
   localparam logic [15:0] WEIGHT_ONE = 16'd32768;

   // lattice hash constants
   localparam logic [31:0] HASH_X   = 32'd374761393;
   localparam logic [31:0] HASH_Y   = 32'd668265263;
   localparam logic [31:0] HASH_Z   = 32'd2147483647;
   localparam logic [31:0] HASH_FIN = 32'd1274126177;

   // 3.0 in Q2.16 for the smoothstep polynomial
   localparam logic [17:0] SMOOTH_THREE = 18'd196608;

   // per octave settings seen by each cell
   typedef struct packed {
      logic [15:0]      gain;
      logic [OCT_W-1:0] oct_eff;
   } fbm_cell_cfg_type;

   // output scaling settings
   typedef struct packed {
      logic signed [23:0] amp;
      logic signed [23:0] bias;
   } fbm_scale_cfg_type;

   // linear blend of two samples, weight in Q1.16
   function automatic logic [NOISE_W-1:0] blend(input logic [NOISE_W-1:0] a,
                                                input logic [NOISE_W-1:0] b,
                                                input logic [16:0] w);
      logic [NOISE_W+16:0] s;
      s = (NOISE_W+17)'(a) * (NOISE_W+17)'(17'd65536 - w)
        + (NOISE_W+17)'(b) * (NOISE_W+17)'(w);
      return s[NOISE_W+15:16];
   endfunction

endpackage

>>> design/fbm_front.sv
// fbm_front: offset subtract and frequency scale into lattice space
// depends on fbm_pkg

module fbm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [31:0]                  in_x,
   input  logic signed [31:0]                  in_y,
   input  logic signed [31:0]                  in_z,
   input  logic signed [31:0]                  off_x,
   input  logic signed [31:0]                  off_y,
   input  logic signed [31:0]                  off_z,
   input  logic [23:0]                         freq,
   output logic                                out_valid,
   output logic signed [fbm_pkg::COORD_W-1:0]  out_cx,
   output logic signed [fbm_pkg::COORD_W-1:0]  out_cy,
   output logic signed [fbm_pkg::COORD_W-1:0]  out_cz
);
   import fbm_pkg::*;

   logic signed [32:0]        d_in [3];
   logic signed [32:0]        d_ff [3];
   logic signed [57:0]        prod [3];
   logic signed [COORD_W-1:0] c_in [3];
   logic signed [COORD_W-1:0] c_ff [3];
   logic                      v1_ff;
   logic                      v2_ff;

   // offset subtract, 33 bit difference
   always_comb begin
      d_in[0] = 33'(in_x) - 33'(off_x);
      d_in[1] = 33'(in_y) - 33'(off_y);
      d_in[2] = 33'(in_z) - 33'(off_z);
   end

   // frequency scale, keep bits 16 and up
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = d_ff[k] * $signed({1'b0, freq});
         c_in[k] = {{(COORD_W-42){prod[k][57]}}, prod[k][57:16]};
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
         c_ff <= c_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cx    = c_ff[0];
   assign out_cy    = c_ff[1];
   assign out_cz    = c_ff[2];

endmodule

>>> design/fbm_cell.sv
// fbm_cell: one octave of 3d value noise, accumulates into the running sums
// depends on fbm_pkg

module fbm_cell #(
   parameter int CELL_IDX      = 0,
   parameter int WW            = 24,
   parameter int LACUNARITY_Q8 = 512
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  fbm_pkg::fbm_cell_cfg_type               cfg,
   input  logic                                    in_valid,
   input  logic signed [fbm_pkg::COORD_W-1:0]      in_cx,
   input  logic signed [fbm_pkg::COORD_W-1:0]      in_cy,
   input  logic signed [fbm_pkg::COORD_W-1:0]      in_cz,
   input  logic [WW-1:0]                           in_weight,
   input  logic [WW-1:0]                           in_wsum,
   input  logic [WW+fbm_pkg::NOISE_W-1:0]          in_total,
   output logic                                    out_valid,
   output logic signed [fbm_pkg::COORD_W-1:0]      out_cx,
   output logic signed [fbm_pkg::COORD_W-1:0]      out_cy,
   output logic signed [fbm_pkg::COORD_W-1:0]      out_cz,
   output logic [WW-1:0]                           out_weight,
   output logic [WW-1:0]                           out_wsum,
   output logic [WW+fbm_pkg::NOISE_W-1:0]          out_total
);
   import fbm_pkg::*;

   localparam int TW = WW + NOISE_W;
   localparam int SD = CELL_STAGES - 1;
   localparam logic signed [11:0] LAC = 12'(LACUNARITY_Q8);
   localparam logic [31:0] HASH_MUL [3] = '{HASH_X, HASH_Y, HASH_Z};

   logic                      act;
   logic [CELL_STAGES-1:0]    v_ff;

   // side data carried down the cell
   logic signed [COORD_W-1:0] cn_sd [SD][3];
   logic [WW-1:0]             wt_sd [SD];
   logic [WW-1:0]             wn_sd [SD];
   logic [WW-1:0]             ws_sd [SD];
   logic [TW-1:0]             tot_sd [SD];

   // stage 1 signals
   logic signed [COORD_W-1:0] c_in [3];
   logic signed [COORD_W-1:0] cn_in [3];
   logic signed [59:0]        lp [3];
   logic [WW+15:0]            gp;
   logic [31:0]               hm_in [3];
   logic [31:0]               tt_in [3];
   logic [31:0]               hm1_ff [3];
   logic [31:0]               tt1_ff [3];
   logic [15:0]               t1_ff [3];

   // stage 2 signals
   logic [31:0]               hv [3][2];
   logic [31:0]               hs [8];
   logic [31:0]               h_in [8];
   logic [49:0]               sp [3];
   logic [16:0]               w_in [3];
   logic [31:0]               h2_ff [8];
   logic [16:0]               w2_ff [3];

   // stage 3 to 7 signals
   logic [31:0]               m3_ff [8];
   logic [16:0]               w3_ff [3];
   logic [NOISE_W-1:0]        cv [8];
   logic [NOISE_W-1:0]        a4_ff [4];
   logic [16:0]               w4_ff [2];
   logic [NOISE_W-1:0]        b5_ff [2];
   logic [16:0]               w5_ff;
   logic [NOISE_W-1:0]        n6_ff;
   logic [TW-1:0]             p7_ff;

   // output registers
   logic signed [COORD_W-1:0] co_ff [3];
   logic [WW-1:0]             wo_ff;
   logic [WW-1:0]             so_ff;
   logic [TW-1:0]             to_ff;

   // this octave counts when it lies below the octave count
   assign act = (OCT_W'(CELL_IDX) < cfg.oct_eff);

   // stage 1: lattice split, hash products, t squared, next octave coords and weight
   always_comb begin
      c_in[0] = in_cx;
      c_in[1] = in_cy;
      c_in[2] = in_cz;
      for (int k = 0; k < 3; k++) begin
         hm_in[k] = c_in[k][47:16] * HASH_MUL[k];
         tt_in[k] = 32'(c_in[k][15:0]) * 32'(c_in[k][15:0]);
         lp[k]    = c_in[k] * LAC;
         cn_in[k] = lp[k][55:8];
      end
      gp = (WW+16)'(in_weight) * (WW+16)'(cfg.gain);
   end

   // stage 2: corner hash sums and smoothstep weights
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hv[k][0] = hm1_ff[k];
         hv[k][1] = hm1_ff[k] + HASH_MUL[k];
         sp[k]    = 50'(tt1_ff[k]) * 50'(SMOOTH_THREE - {1'b0, t1_ff[k], 1'b0});
         w_in[k]  = sp[k][48:32];
      end
      for (int j = 0; j < 8; j++) begin
         hs[j]   = hv[0][j % 2] + hv[1][(j / 2) % 2] + hv[2][j / 4];
         h_in[j] = hs[j] ^ (hs[j] >> 13);
      end
   end

   // stage 4 corner values from the final mix
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         cv[j] = m3_ff[j][NOISE_W-1:0] ^ {8'h00, m3_ff[j][31:16]};
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[CELL_STAGES-2:0], in_valid};
      end
   end

   // side data shift
   always_ff @(posedge clock) begin
      if (adv) begin
         cn_sd[0]  <= cn_in;
         wt_sd[0]  <= in_weight;
         wn_sd[0]  <= gp[WW+14:15];
         ws_sd[0]  <= in_wsum;
         tot_sd[0] <= in_total;
         for (int s = 1; s < SD; s++) begin
            cn_sd[s]  <= cn_sd[s-1];
            wt_sd[s]  <= wt_sd[s-1];
            wn_sd[s]  <= wn_sd[s-1];
            ws_sd[s]  <= ws_sd[s-1];
            tot_sd[s] <= tot_sd[s-1];
         end
      end
   end

   // noise datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         hm1_ff <= hm_in;
         tt1_ff <= tt_in;
         for (int k = 0; k < 3; k++) begin
            t1_ff[k] <= c_in[k][15:0];
         end
         h2_ff <= h_in;
         w2_ff <= w_in;
         for (int j = 0; j < 8; j++) begin
            m3_ff[j] <= h2_ff[j] * HASH_FIN;
         end
         w3_ff <= w2_ff;
         for (int k = 0; k < 4; k++) begin
            a4_ff[k] <= blend(cv[2*k], cv[2*k+1], w3_ff[0]);
         end
         w4_ff[0] <= w3_ff[1];
         w4_ff[1] <= w3_ff[2];
         for (int z = 0; z < 2; z++) begin
            b5_ff[z] <= blend(a4_ff[2*z], a4_ff[2*z+1], w4_ff[0]);
         end
         w5_ff <= w4_ff[1];
         n6_ff <= blend(b5_ff[0], b5_ff[1], w5_ff);
         p7_ff <= TW'(wt_sd[SD-2]) * TW'(n6_ff);
      end
   end

   // accumulate into the running sums
   always_ff @(posedge clock) begin
      if (adv) begin
         co_ff <= cn_sd[SD-1];
         wo_ff <= act ? wn_sd[SD-1] : wt_sd[SD-1];
         so_ff <= act ? ws_sd[SD-1] + wt_sd[SD-1] : ws_sd[SD-1];
         to_ff <= act ? tot_sd[SD-1] + p7_ff : tot_sd[SD-1];
      end
   end

   assign out_valid  = v_ff[CELL_STAGES-1];
   assign out_cx     = co_ff[0];
   assign out_cy     = co_ff[1];
   assign out_cz     = co_ff[2];
   assign out_weight = wo_ff;
   assign out_wsum   = so_ff;
   assign out_total  = to_ff;

endmodule

>>> design/fbm_div_cell.sv
// fbm_div_cell: one restoring divide step, one quotient bit per cell
// depends on fbm_pkg

module fbm_div_cell #(
   parameter int WW = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [WW-1:0]                   in_rem,
   input  logic [fbm_pkg::NOISE_W-1:0]     in_nlo,
   input  logic [WW-1:0]                   in_den,
   input  logic [fbm_pkg::NOISE_W-1:0]     in_q,
   output logic                            out_valid,
   output logic [WW-1:0]                   out_rem,
   output logic [fbm_pkg::NOISE_W-1:0]     out_nlo,
   output logic [WW-1:0]                   out_den,
   output logic [fbm_pkg::NOISE_W-1:0]     out_q
);
   import fbm_pkg::*;

   logic [WW:0]         r2;
   logic [WW:0]         diff;
   logic                ge;
   logic                v_ff;
   logic [WW-1:0]       rem_ff;
   logic [NOISE_W-1:0]  nlo_ff;
   logic [WW-1:0]       den_ff;
   logic [NOISE_W-1:0]  q_ff;

   // trial subtract of the shifted remainder
   always_comb begin
      r2   = {in_rem, in_nlo[NOISE_W-1]};
      diff = r2 - {1'b0, in_den};
      ge   = (r2 >= {1'b0, in_den});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= ge ? diff[WW-1:0] : r2[WW-1:0];
         nlo_ff <= {in_nlo[NOISE_W-2:0], 1'b0};
         den_ff <= in_den;
         q_ff   <= {in_q[NOISE_W-2:0], ge};
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_nlo   = nlo_ff;
   assign out_den   = den_ff;
   assign out_q     = q_ff;

endmodule

>>> design/fbm_back.sv
// fbm_back: normalise by the weight sum, scale, bias and clamp
// depends on fbm_pkg and fbm_div_cell

module fbm_back #(
   parameter int WW = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  fbm_pkg::fbm_scale_cfg_type           cfg,
   input  logic                                 in_valid,
   input  logic [WW-1:0]                        in_wsum,
   input  logic [WW+fbm_pkg::NOISE_W-1:0]       in_total,
   output logic                                 out_valid,
   output logic [23:0]                          out_density
);
   import fbm_pkg::*;

   localparam int TW = WW + NOISE_W;

   logic                dv  [NOISE_W+1];
   logic [WW-1:0]       dr  [NOISE_W+1];
   logic [NOISE_W-1:0]  dn  [NOISE_W+1];
   logic [WW-1:0]       dd  [NOISE_W+1];
   logic [NOISE_W-1:0]  dq  [NOISE_W+1];

   logic                sc_valid_ff;
   logic signed [48:0]  prod_ff;
   logic signed [24:0]  vt;
   logic signed [25:0]  sum;

   // divider seed, the top bits of the total are already below the sum
   assign dv[0] = in_valid;
   assign dr[0] = in_total[TW-1:NOISE_W];
   assign dn[0] = in_total[NOISE_W-1:0];
   assign dd[0] = in_wsum;
   assign dq[0] = '0;

   // one cell per quotient bit
   for (genvar i = 0; i < NOISE_W; i++) begin : g_div
      fbm_div_cell #(.WW(WW)) u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv[i]),
         .in_rem    (dr[i]),
         .in_nlo    (dn[i]),
         .in_den    (dd[i]),
         .in_q      (dq[i]),
         .out_valid (dv[i+1]),
         .out_rem   (dr[i+1]),
         .out_nlo   (dn[i+1]),
         .out_den   (dd[i+1]),
         .out_q     (dq[i+1])
      );
   end

   // amplitude product
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (adv) begin
         sc_valid_ff <= dv[NOISE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= cfg.amp * $signed({1'b0, dq[NOISE_W]});
      end
   end

   // floor shift toward minus infinity, add bias, clamp to the output range
   always_comb begin
      vt  = prod_ff[48:24];
      sum = 26'(vt) + 26'(cfg.bias);
      if (sum < 0) begin
         out_density = '0;
      end else if (sum > 26'sh0FFFFFF) begin
         out_density = 24'hFFFFFF;
      end else begin
         out_density = sum[23:0];
      end
   end

   assign out_valid = sc_valid_ff;

endmodule

>>> design/fbm_value_noise_density.sv
// fbm_value_noise_density: top level, configuration registers, octave chain, output beat
// depends on fbm_pkg, fbm_front, fbm_cell, fbm_back
//
// usage
// - the req channel takes one sample point per beat (req_pos_x/y/z, Q16.16);
//   the rsp channel returns one rsp_density per point (unsigned Q8.16), in order
// - throughput is one point per cycle while req_stall is low; a point moves
//   through two front stages, one eight stage cell per octave (MAX_OCTAVES cells,
//   all always traversed), a 24 cell divider and one scale stage
// - rsp_valid comes from the output beat register behind the scale stage
// - the whole pipeline advances together; when rsp_stall holds a waiting result
//   and a new one has reached the pipeline end, req_stall is raised and
//   everything holds; otherwise points keep entering behind the waiting result
// - the csr port writes one register per cycle with csr_write; writes are
//   meant for idle periods only and are not read back
// - reset clears all valids and loads the register defaults; no clearing pass

module fbm_value_noise_density #(
   parameter int LACUNARITY_Q8 = 512,
   parameter int MAX_OCTAVES   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_pos_x,
   input  logic signed [31:0]                  req_pos_y,
   input  logic signed [31:0]                  req_pos_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [23:0]                         rsp_density,
   input  logic                                csr_write,
   input  logic [fbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fbm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import fbm_pkg::*;

   localparam int WW = 16 + MAX_OCTAVES;
   localparam int TW = WW + NOISE_W;

   // configuration registers
   logic signed [31:0]  offset_x_ff;
   logic signed [31:0]  offset_y_ff;
   logic signed [31:0]  offset_z_ff;
   logic [23:0]         frequency_ff;
   logic [3:0]          octave_count_ff;
   logic [15:0]         octave_gain_ff;
   logic signed [23:0]  amplitude_ff;
   logic signed [23:0]  bias_ff;

   logic [OCT_W-1:0]    oct_eff;
   fbm_cell_cfg_type    cell_cfg;
   fbm_scale_cfg_type   scale_cfg;

   logic                adv;
   logic                back_valid;
   logic [23:0]         back_density;
   logic                rsp_valid_ff;
   logic [23:0]         rsp_density_ff;

   // octave chain links
   logic                      ch_valid  [MAX_OCTAVES+1];
   logic signed [COORD_W-1:0] ch_cx     [MAX_OCTAVES+1];
   logic signed [COORD_W-1:0] ch_cy     [MAX_OCTAVES+1];
   logic signed [COORD_W-1:0] ch_cz     [MAX_OCTAVES+1];
   logic [WW-1:0]             ch_weight [MAX_OCTAVES+1];
   logic [WW-1:0]             ch_wsum   [MAX_OCTAVES+1];
   logic [TW-1:0]             ch_total  [MAX_OCTAVES+1];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff     <= '0;
         offset_y_ff     <= '0;
         offset_z_ff     <= '0;
         frequency_ff    <= FREQUENCY_RST;
         octave_count_ff <= OCTAVE_COUNT_RST;
         octave_gain_ff  <= OCTAVE_GAIN_RST;
         amplitude_ff    <= AMPLITUDE_RST;
         bias_ff         <= '0;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_OFFSET_X:     offset_x_ff     <= csr_data[31:0];
            REG_OFFSET_Y:     offset_y_ff     <= csr_data[31:0];
            REG_OFFSET_Z:     offset_z_ff     <= csr_data[31:0];
            REG_FREQUENCY:    frequency_ff    <= csr_data[23:0];
            REG_OCTAVE_COUNT: octave_count_ff <= csr_data[3:0];
            REG_OCTAVE_GAIN:  octave_gain_ff  <= csr_data[15:0];
            REG_AMPLITUDE:    amplitude_ff    <= csr_data[23:0];
            REG_BIAS:         bias_ff         <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // effective octave count, zero means one, limited to the chain length
   always_comb begin
      if (octave_count_ff == '0) begin
         oct_eff = OCT_W'(1);
      end else if (OCT_W'(octave_count_ff) > OCT_W'(MAX_OCTAVES)) begin
         oct_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_eff = OCT_W'(octave_count_ff);
      end
      cell_cfg.gain     = octave_gain_ff;
      cell_cfg.oct_eff  = oct_eff;
      scale_cfg.amp     = amplitude_ff;
      scale_cfg.bias    = bias_ff;
   end

   // the pipeline moves unless a finished result would overrun the output beat
   assign adv       = !back_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   fbm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_x      (req_pos_x),
      .in_y      (req_pos_y),
      .in_z      (req_pos_z),
      .off_x     (offset_x_ff),
      .off_y     (offset_y_ff),
      .off_z     (offset_z_ff),
      .freq      (frequency_ff),
      .out_valid (ch_valid[0]),
      .out_cx    (ch_cx[0]),
      .out_cy    (ch_cy[0]),
      .out_cz    (ch_cz[0])
   );

   // running sums start empty with unit weight
   assign ch_weight[0] = WW'(WEIGHT_ONE);
   assign ch_wsum[0]   = '0;
   assign ch_total[0]  = '0;

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      fbm_cell #(
         .CELL_IDX      (i),
         .WW            (WW),
         .LACUNARITY_Q8 (LACUNARITY_Q8)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .cfg        (cell_cfg),
         .in_valid   (ch_valid[i]),
         .in_cx      (ch_cx[i]),
         .in_cy      (ch_cy[i]),
         .in_cz      (ch_cz[i]),
         .in_weight  (ch_weight[i]),
         .in_wsum    (ch_wsum[i]),
         .in_total   (ch_total[i]),
         .out_valid  (ch_valid[i+1]),
         .out_cx     (ch_cx[i+1]),
         .out_cy     (ch_cy[i+1]),
         .out_cz     (ch_cz[i+1]),
         .out_weight (ch_weight[i+1]),
         .out_wsum   (ch_wsum[i+1]),
         .out_total  (ch_total[i+1])
      );
   end

   fbm_back #(.WW(WW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .cfg         (scale_cfg),
      .in_valid    (ch_valid[MAX_OCTAVES]),
      .in_wsum     (ch_wsum[MAX_OCTAVES]),
      .in_total    (ch_total[MAX_OCTAVES]),
      .out_valid   (back_valid),
      .out_density (back_density)
   );

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && back_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && back_valid) begin
         rsp_density_ff <= back_density;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_density = rsp_density_ff;

   // a waiting result with another one behind it stops the input
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && back_valid) |-> req_stall)
      else $error("input taken while the output beat was full");

   // a taken beat with nothing behind it empties the output register
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !back_valid) |=> !rsp_valid_ff)
      else $error("output beat repeated");

   // a finished result is never dropped while the output is held
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (back_valid && rsp_valid_ff && rsp_stall) |=> (back_valid && rsp_valid_ff))
      else $error("result lost under stall");

   // effective octave count stays inside the chain
   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (oct_eff != '0) && (oct_eff <= OCT_W'(MAX_OCTAVES)))
      else $error("octave count out of range");

   // reset empties the output
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

endmodule
